// File: design/i2c_bitbang_master_assert.svh
// Assertion macros for the bit-level I2C master.
`ifndef I2C_BITBANG_MASTER_ASSERT_SVH
`define I2C_BITBANG_MASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CBB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cbb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define I2CBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cbb: next-cycle check failed");

`endif

// File: design/i2cbb_pkg.sv
package i2cbb_pkg;

   // Command codes carried in the mode field
   typedef enum logic [2:0] {
      MODE_START    = 3'd0,
      MODE_STOP     = 3'd1,
      MODE_RELEASE  = 3'd2,
      MODE_ACK      = 3'd3,
      MODE_NACK     = 3'd4,
      MODE_WAIT_ACK = 3'd5,
      MODE_SEND     = 3'd6,
      MODE_RECEIVE  = 3'd7
   } mode_type;

   localparam int unsigned DELAY_W   = 8;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STEP_W    = 3;
   localparam int unsigned BITCNT_W  = 4;

   localparam logic [DELAY_W-1:0]  HALF_DELAY_RESET = 8'd100;
   localparam logic [BITCNT_W-1:0] BYTE_BITS        = 4'd8;
   localparam logic [BITCNT_W-1:0] RELEASE_PULSES   = 4'd9;

endpackage

// File: design/i2cbb_if.sv
// Command channel: one item per bus tick
interface i2cbb_req_if
   import i2cbb_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                start_cmd;
   logic [2:0]          mode;
   logic [BYTE_W-1:0]   tx_byte;
   logic                sda_in;

   modport source (output valid, start_cmd, mode, tx_byte, sda_in, input ready);
   modport sink   (input valid, start_cmd, mode, tx_byte, sda_in, output ready);
endinterface

// Result channel: line levels and status after each tick
interface i2cbb_rsp_if
   import i2cbb_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                scl_level;
   logic                sda_level;
   logic                busy_res;
   logic                done_res;
   logic                ok;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, ok, rx_byte,
                   input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, ok, rx_byte,
                   output ready);
endinterface

// Register write channel for half_delay
interface i2cbb_csr_if
   import i2cbb_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [DELAY_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: design/i2c_bitbang_master.sv
// Bit-level I2C master. Every command item is one bus tick: it carries the
// sampled SDA level and may start a command (start, stop, bus release, ack,
// nack, wait-for-ack, send byte, receive byte) when the master is idle. Each
// accepted item returns exactly one result item with the SCL/SDA levels, busy,
// done, ok and the last received byte, as they stand after that tick. The
// sequencer state itself is the result register, so an item is taken every
// cycle; the result appears in the cycle after its item and req_ch.ready drops
// only while a result is waiting and rsp_ch.ready is low. half_delay (reset
// 100, zero treated as one) sets the ticks per half-bit delay and must be
// written through csr_ch only while the master is idle; not enforced here.
`include "i2c_bitbang_master_assert.svh"

module i2c_bitbang_master
   import i2cbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cbb_req_if.sink   req_ch,
   i2cbb_rsp_if.source rsp_ch,
   i2cbb_csr_if.sink   csr_ch
);

   logic [DELAY_W-1:0]  half_delay_ff;
   mode_type            mode_ff,    mode_in;
   logic                running_ff, running_in;
   logic [STEP_W-1:0]   step_ff,    step_in;
   logic [BITCNT_W-1:0] bitcnt_ff,  bitcnt_in;
   logic [DELAY_W-1:0]  delay_ff,   delay_in;
   logic [BYTE_W-1:0]   shift_ff,   shift_in;
   logic [BYTE_W-1:0]   rx_ff,      rx_in;
   logic                scl_ff,     scl_in;
   logic                sda_ff,     sda_in_nx;
   logic                ok_ff,      ok_in;
   logic                done_ff,    done_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept;
   logic [DELAY_W-1:0]  arm_value;
   logic [DELAY_W-1:0]  delay_dec;
   logic [BITCNT_W-1:0] bitcnt_inc;
   logic [BYTE_W-1:0]   shift_rx;
   mode_type            req_mode;

   // Handshake: stall input only while a result waits
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign req_mode   = mode_type'(req_ch.mode);
   assign arm_value  = (half_delay_ff == '0) ? DELAY_W'(1) : half_delay_ff;
   assign delay_dec  = delay_ff - DELAY_W'(1);
   assign bitcnt_inc = bitcnt_ff + BITCNT_W'(1);
   assign shift_rx   = shift_ff | BYTE_W'(req_ch.sda_in);

   // Next state of the bus sequencer for one tick
   always_comb begin
      mode_in    = mode_ff;
      running_in = running_ff;
      step_in    = step_ff;
      bitcnt_in  = bitcnt_ff;
      delay_in   = delay_ff;
      shift_in   = shift_ff;
      rx_in      = rx_ff;
      scl_in     = scl_ff;
      sda_in_nx  = sda_ff;
      ok_in      = ok_ff;
      done_in    = 1'b0;

      if (running_ff) begin
         delay_in = delay_dec;
         if (delay_dec == '0) begin
            step_in = step_ff + STEP_W'(1);
            unique case (mode_ff)
               MODE_START: begin
                  if (step_ff == '0) begin
                     if (!req_ch.sda_in) begin
                        running_in = 1'b0; ok_in = 1'b0; done_in = 1'b1;
                     end else begin
                        sda_in_nx = 1'b0; delay_in = arm_value;
                     end
                  end else begin
                     if (req_ch.sda_in) begin
                        running_in = 1'b0; ok_in = 1'b0; done_in = 1'b1;
                     end else begin
                        scl_in = 1'b0;
                        running_in = 1'b0; ok_in = 1'b1; done_in = 1'b1;
                     end
                  end
               end
               MODE_STOP, MODE_RELEASE: begin
                  // release runs pulses in steps 0..1, then the stop tail
                  priority if (mode_ff == MODE_RELEASE && step_ff == STEP_W'(0)) begin
                     scl_in = 1'b0; delay_in = arm_value;
                  end else if (mode_ff == MODE_RELEASE && step_ff == STEP_W'(1)) begin
                     bitcnt_in = bitcnt_inc;
                     if (bitcnt_inc < RELEASE_PULSES) begin
                        scl_in = 1'b1; step_in = '0;
                     end else begin
                        scl_in = 1'b0;
                     end
                     delay_in = arm_value;
                  end else if ((mode_ff == MODE_STOP && step_ff == STEP_W'(0)) ||
                               (mode_ff == MODE_RELEASE && step_ff == STEP_W'(2))) begin
                     sda_in_nx = 1'b0; delay_in = arm_value;
                  end else if ((mode_ff == MODE_STOP && step_ff == STEP_W'(1)) ||
                               (mode_ff == MODE_RELEASE && step_ff == STEP_W'(3))) begin
                     scl_in = 1'b1; delay_in = arm_value;
                  end else begin
                     sda_in_nx = 1'b1;
                     running_in = 1'b0; ok_in = 1'b1; done_in = 1'b1;
                  end
               end
               MODE_ACK, MODE_NACK: begin
                  priority if (step_ff == STEP_W'(0)) begin
                     sda_in_nx = (mode_ff == MODE_NACK); delay_in = arm_value;
                  end else if (step_ff == STEP_W'(1)) begin
                     scl_in = 1'b1; delay_in = arm_value;
                  end else if (step_ff == STEP_W'(2)) begin
                     scl_in = 1'b0; delay_in = arm_value;
                  end else begin
                     running_in = 1'b0; ok_in = 1'b1; done_in = 1'b1;
                  end
               end
               MODE_WAIT_ACK: begin
                  priority if (step_ff == STEP_W'(0)) begin
                     sda_in_nx = 1'b1; delay_in = arm_value;
                  end else if (step_ff == STEP_W'(1)) begin
                     scl_in = 1'b1; delay_in = arm_value;
                  end else begin
                     scl_in = 1'b0;
                     running_in = 1'b0; ok_in = !req_ch.sda_in; done_in = 1'b1;
                  end
               end
               MODE_SEND: begin
                  priority if (step_ff == STEP_W'(0)) begin
                     sda_in_nx = shift_ff[BYTE_W-1];
                     shift_in  = {shift_ff[BYTE_W-2:0], 1'b0};
                     delay_in  = arm_value;
                  end else if (step_ff == STEP_W'(1)) begin
                     scl_in = 1'b1; delay_in = arm_value;
                  end else begin
                     scl_in = 1'b0;
                     bitcnt_in = bitcnt_inc;
                     if (bitcnt_inc < BYTE_BITS) begin
                        step_in = '0; delay_in = arm_value;
                     end else begin
                        running_in = 1'b0; ok_in = 1'b1; done_in = 1'b1;
                     end
                  end
               end
               MODE_RECEIVE: begin
                  if (step_ff == STEP_W'(0)) begin
                     scl_in = 1'b1; delay_in = arm_value;
                  end else begin
                     scl_in = 1'b0;
                     bitcnt_in = bitcnt_inc;
                     if (bitcnt_inc < BYTE_BITS) begin
                        shift_in = {shift_rx[BYTE_W-2:0], 1'b0};
                        step_in  = '0;
                        delay_in = arm_value;
                     end else begin
                        shift_in = shift_rx;
                        rx_in    = shift_rx;
                        running_in = 1'b0; ok_in = 1'b1; done_in = 1'b1;
                     end
                  end
               end
            endcase
         end
      end else if (req_ch.start_cmd) begin
         // begin a command
         mode_in    = req_mode;
         running_in = 1'b1;
         step_in    = '0;
         bitcnt_in  = '0;
         delay_in   = arm_value;
         unique case (req_mode)
            MODE_START: begin
               sda_in_nx = 1'b1; scl_in = 1'b1;
            end
            MODE_RELEASE: scl_in = 1'b1;
            MODE_SEND: begin
               shift_in = req_ch.tx_byte; scl_in = 1'b0;
            end
            MODE_RECEIVE: begin
               sda_in_nx = 1'b1; shift_in = '0; scl_in = 1'b0;
            end
            MODE_STOP, MODE_ACK, MODE_NACK, MODE_WAIT_ACK: scl_in = 1'b0;
         endcase
      end
   end

   // Result valid flag
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Sequencer state, doubling as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_delay_ff <= HALF_DELAY_RESET;
         mode_ff       <= MODE_START;
         running_ff    <= 1'b0;
         step_ff       <= '0;
         bitcnt_ff     <= '0;
         delay_ff      <= '0;
         shift_ff      <= '0;
         rx_ff         <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ok_ff         <= 1'b1;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            half_delay_ff <= csr_ch.data;
         end
         if (accept) begin
            mode_ff    <= mode_in;
            running_ff <= running_in;
            step_ff    <= step_in;
            bitcnt_ff  <= bitcnt_in;
            delay_ff   <= delay_in;
            shift_ff   <= shift_in;
            rx_ff      <= rx_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in_nx;
            ok_ff      <= ok_in;
            done_ff    <= done_in;
         end
      end
   end

   // Result item
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.scl_level = scl_ff;
   assign rsp_ch.sda_level = sda_ff;
   assign rsp_ch.busy_res  = running_ff;
   assign rsp_ch.done_res  = done_ff;
   assign rsp_ch.ok        = ok_ff;
   assign rsp_ch.rx_byte   = rx_ff;

   // Checks
   `I2CBB_ASSERT_IMPLY(a_done_not_busy, clock, reset, done_ff, !running_ff)
   `I2CBB_ASSERT_IMPLY(a_delay_armed, clock, reset, running_ff, delay_ff != '0)
   `I2CBB_ASSERT_NEXT(a_cmd_starts, clock, reset, accept && !running_ff && req_ch.start_cmd, running_ff && !done_ff)

endmodule
